// ===== sv/dlbd_pkg.sv =====
// Package for the dual-level bar graph delta drawer.
// Payload structs, controller state and command/status types, register indexes.
// No dependencies.
package dlbd_pkg;

    localparam int LEN_W   = 10;
    localparam int COORD_W = 11;
    localparam int COL_W   = 16;
    localparam int LVL_W   = 16;
    localparam int FS_W    = 15;
    localparam int PROD_W  = LEN_W + FS_W;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 4;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(LEN_W - 1);

    localparam logic [IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BAR_LENGTH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BAR_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOW_COLOUR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HIGH_COLOUR  = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLANK_COLOUR = 3'd6;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ERASE  = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [LVL_W-1:0]  low_level;
        logic signed [LVL_W-1:0]  high_level;
        logic [FS_W-1:0]          full_scale;
    } in_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [LEN_W-1:0]   rect_width;
        logic [LEN_W-1:0]   rect_height;
        logic [COL_W-1:0]   fill_colour;
        logic               last_rect;
    } out_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic sel_high;
        logic div_load;
        logic div_step;
        logic store;
        logic plan;
        logic load_out;
        logic out_idx;
    } cmd_t;

    typedef struct packed {
        logic       is_erase;
        logic [1:0] rect_cnt;
        logic       out_free;
    } status_t;

endpackage

// ===== sv/dual_level_bargraph_delta_drawer.sv =====
// Dual-level bar graph delta drawer, top level.
// Joins the controller (dlbd_ctrl) and the datapath (dlbd_dpath); uses dlbd_pkg.
//
// Usage: configure origin, bar length/height and colours through the write
// port (cfg_wr_en, cfg_index, cfg_wr_data) while the block is idle. Each
// request on s_valid/s_ready carries an opcode and two signed levels with a
// full scale. For an update both levels are clamped, scaled to bar lengths
// and compared with the lengths drawn last; zero to two fill-rectangle
// requests leave on m_valid/m_ready, the final one flagged by last_rect.
// An erase blanks the drawn bar in one rectangle, or emits nothing if the
// bar is empty.
// Sequence: an update runs two passes of multiply and 10-step serial divide
// on one shared multiplier and divider, one pass per level, then the planning
// state and the output register load; an erase goes from the multiply state
// straight to planning. A new request is taken only once the block is back
// in idle, after its last rectangle, if any, is loaded.
// The next request is accepted while the last rectangle still waits in the
// output register; a stalled receiver holds the rectangle output and stops
// the block at its next rectangle. Reset clears the configuration
// registers, both drawn lengths and the output valid.
module dual_level_bargraph_delta_drawer
    import dlbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_req_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_req_t         m_data
);

    cmd_t    cmd;
    status_t status;

    dlbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dlbd_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== sv/dlbd_ctrl.sv =====
// Controller state machine for the bar graph delta drawer.
// Sequences multiply, serial divide, planning and rectangle output.
// Depends on dlbd_pkg.
module dlbd_ctrl
    import dlbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic             sel_reg, sel_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             idx_reg, idx_next;
    logic             emit_last;

    assign emit_last = (status.rect_cnt == 2'd1 && !idx_reg) || idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                sel_next = 1'b0;
                idx_next = 1'b0;
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = status.is_erase ? ST_PLAN : ST_LOAD;
            end
            ST_LOAD: begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (sel_reg) begin
                    state_next = ST_PLAN;
                end else begin
                    sel_next   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_PLAN: begin
                idx_next   = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.rect_cnt == 2'd0) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    idx_next = 1'b1;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_ready  = 1'b0;
        cmd.sel_high = sel_reg;
        cmd.out_idx  = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_MUL:   cmd.mul      = 1'b1;
            ST_LOAD:  cmd.div_load = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_STORE: cmd.store    = 1'b1;
            ST_PLAN:  cmd.plan     = 1'b1;
            ST_EMIT: begin
                cmd.load_out = (status.rect_cnt != 2'd0) && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/dlbd_dpath.sv =====
// Datapath for the bar graph delta drawer: config registers, multiplier,
// restoring divider, drawn-length state, rectangle planner and output register.
// Depends on dlbd_pkg.
module dlbd_dpath
    import dlbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  in_req_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_req_t         m_data,
    input  cmd_t             cmd,
    output status_t          status
);

    logic [LEN_W-1:0]  origin_x_reg, origin_y_reg, bar_length_reg, bar_height_reg;
    logic [COL_W-1:0]  low_colour_reg, high_colour_reg, blank_colour_reg;

    in_req_t           in_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [FS_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]  quo_reg, quo_next;
    logic [LEN_W-1:0]  lo_reg, hi_reg;
    logic [LEN_W-1:0]  ol_reg, oh_reg;

    logic [LEN_W-1:0]  a_start_reg, a_wid_reg, b_start_reg, b_wid_reg;
    logic [COL_W-1:0]  a_col_reg, b_col_reg;
    logic [1:0]        cnt_reg;

    logic              out_valid_reg;
    out_req_t          out_reg;

    logic signed [LVL_W-1:0] level;
    logic [FS_W-1:0]   lv;
    logic [FS_W:0]     trial, diff;
    logic              qbit;

    logic [LEN_W-1:0]  lo, hi, ol, oh;
    logic [LEN_W-1:0]  a_start, a_wid, b_start, b_wid;
    logic [COL_W-1:0]  a_col, b_col;
    logic [1:0]        cnt;
    logic [LEN_W-1:0]  e_start, e_wid;
    logic [COL_W-1:0]  e_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            bar_length_reg   <= '0;
            bar_height_reg   <= '0;
            low_colour_reg   <= '0;
            high_colour_reg  <= '0;
            blank_colour_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_wr_data[LEN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_wr_data[LEN_W-1:0];
                REG_BAR_LENGTH:   bar_length_reg   <= cfg_wr_data[LEN_W-1:0];
                REG_BAR_HEIGHT:   bar_height_reg   <= cfg_wr_data[LEN_W-1:0];
                REG_LOW_COLOUR:   low_colour_reg   <= cfg_wr_data;
                REG_HIGH_COLOUR:  high_colour_reg  <= cfg_wr_data;
                REG_BLANK_COLOUR: blank_colour_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // clamp selected level to 0..full_scale
    always_comb begin
        level = cmd.sel_high ? in_reg.high_level : in_reg.low_level;
        if (level[LVL_W-1]) begin
            lv = '0;
        end else if (level[FS_W-1:0] > in_reg.full_scale) begin
            lv = in_reg.full_scale;
        end else begin
            lv = level[FS_W-1:0];
        end
    end

    // quotient fits in LEN_W bits, so the top bits of the product seed the remainder
    always_comb begin
        trial = {rem_reg, quo_reg[LEN_W-1]};
        diff  = trial - {1'b0, in_reg.full_scale};
        qbit  = (trial >= {1'b0, in_reg.full_scale});
        rem_next = qbit ? diff[FS_W-1:0] : trial[FS_W-1:0];
        quo_next = {quo_reg[LEN_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(bar_length_reg) * PROD_W'(lv);
        end
        if (cmd.div_load) begin
            rem_reg <= prod_reg[PROD_W-1:LEN_W];
            quo_reg <= prod_reg[LEN_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.store) begin
            if (cmd.sel_high) begin
                hi_reg <= (in_reg.full_scale == '0) ? '0 : quo_reg;
            end else begin
                lo_reg <= (in_reg.full_scale == '0) ? '0 : quo_reg;
            end
        end
    end

    // rectangle planner
    always_comb begin
        lo = lo_reg;
        hi = (hi_reg < lo_reg) ? lo_reg : hi_reg;
        ol = ol_reg;
        oh = oh_reg;
        a_start = '0; a_wid = '0; a_col = '0;
        b_start = '0; b_wid = '0; b_col = '0;
        cnt = 2'd0;
        if (in_reg.opcode == OP_ERASE) begin
            if (oh != '0) begin
                a_start = '0; a_wid = oh; a_col = blank_colour_reg; cnt = 2'd1;
            end
        end else if (lo > ol) begin
            a_start = ol; a_wid = lo - ol; a_col = low_colour_reg; cnt = 2'd1;
            if (hi > oh) begin
                if (oh > lo) begin
                    b_start = oh; b_wid = hi - oh; b_col = high_colour_reg; cnt = 2'd2;
                end else if (hi != lo) begin
                    b_start = lo; b_wid = hi - lo; b_col = high_colour_reg; cnt = 2'd2;
                end
            end else if (hi < oh) begin
                b_start = hi; b_wid = oh - hi; b_col = blank_colour_reg; cnt = 2'd2;
            end
        end else if (lo < ol) begin
            if (hi <= ol) begin
                if (hi != lo) begin
                    a_start = lo; a_wid = hi - lo; a_col = high_colour_reg; cnt = 2'd1;
                    if (oh > hi) begin
                        b_start = hi; b_wid = oh - hi; b_col = blank_colour_reg;
                        cnt = 2'd2;
                    end
                end else if (oh > hi) begin
                    a_start = hi; a_wid = oh - hi; a_col = blank_colour_reg; cnt = 2'd1;
                end
            end else begin
                a_start = lo; a_wid = ol - lo; a_col = high_colour_reg; cnt = 2'd1;
                if (hi < oh) begin
                    b_start = hi; b_wid = oh - hi; b_col = blank_colour_reg; cnt = 2'd2;
                end else if (hi > oh) begin
                    b_start = oh; b_wid = hi - oh; b_col = high_colour_reg; cnt = 2'd2;
                end
            end
        end else if (hi > oh) begin
            a_start = oh; a_wid = hi - oh; a_col = high_colour_reg; cnt = 2'd1;
        end else if (hi < oh) begin
            a_start = hi; a_wid = oh - hi; a_col = blank_colour_reg; cnt = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ol_reg  <= '0;
            oh_reg  <= '0;
            cnt_reg <= 2'd0;
        end else if (cmd.plan) begin
            cnt_reg <= cnt;
            if (in_reg.opcode == OP_ERASE) begin
                ol_reg <= '0;
                oh_reg <= '0;
            end else begin
                ol_reg <= lo;
                oh_reg <= hi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.plan) begin
            a_start_reg <= a_start;
            a_wid_reg   <= a_wid;
            a_col_reg   <= a_col;
            b_start_reg <= b_start;
            b_wid_reg   <= b_wid;
            b_col_reg   <= b_col;
        end
    end

    always_comb begin
        e_start = cmd.out_idx ? b_start_reg : a_start_reg;
        e_wid   = cmd.out_idx ? b_wid_reg   : a_wid_reg;
        e_col   = cmd.out_idx ? b_col_reg   : a_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.rect_x      <= {1'b0, origin_x_reg} + COORD_W'(1) + {1'b0, e_start};
            out_reg.rect_y      <= {1'b0, origin_y_reg} + COORD_W'(1);
            out_reg.rect_width  <= e_wid;
            out_reg.rect_height <= bar_height_reg;
            out_reg.fill_colour <= e_col;
            out_reg.last_rect   <= cmd.out_idx || (cnt_reg == 2'd1);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;
    assign status.is_erase = (in_reg.opcode == OP_ERASE);
    assign status.rect_cnt = cnt_reg;
    assign status.out_free = !out_valid_reg || m_ready;

endmodule
